/* rtl/y86id_pkg.sv */
// y86id_pkg: shared types, codes and constants of the y86-64 instruction decoder
// used by every module of the decoder and by its checker; depends on nothing

`timescale 1ns / 1ps

package y86id_pkg;

  // fixed field widths
  localparam int unsigned ADDR_W  = 13;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned CONST_W = 64;
  localparam int unsigned RAW_W   = 72;            // instruction bytes 1 to 9
  localparam int unsigned END_W   = ADDR_W + 1;    // fetch address plus length
  localparam int unsigned S_TDATA_W = 96;
  localparam int unsigned M_TDATA_W = 88;

  // default size of instruction memory in bytes
  localparam int unsigned MEM_BYTES_DEF = 8192;

  // register nibble that means no register
  localparam logic [NIB_W-1:0] NO_REG = 4'hf;

  // instruction classes
  localparam logic [NIB_W-1:0] CLS_HALT   = 4'h0;
  localparam logic [NIB_W-1:0] CLS_NOP    = 4'h1;
  localparam logic [NIB_W-1:0] CLS_CMOV   = 4'h2;
  localparam logic [NIB_W-1:0] CLS_IRMOVQ = 4'h3;
  localparam logic [NIB_W-1:0] CLS_RMMOVQ = 4'h4;
  localparam logic [NIB_W-1:0] CLS_MRMOVQ = 4'h5;
  localparam logic [NIB_W-1:0] CLS_OPQ    = 4'h6;
  localparam logic [NIB_W-1:0] CLS_JXX    = 4'h7;
  localparam logic [NIB_W-1:0] CLS_CALL   = 4'h8;
  localparam logic [NIB_W-1:0] CLS_RET    = 4'h9;
  localparam logic [NIB_W-1:0] CLS_PUSHQ  = 4'ha;
  localparam logic [NIB_W-1:0] CLS_POPQ   = 4'hb;

  // highest legal function codes
  localparam logic [NIB_W-1:0] FN_MAX_COND = 4'h6;
  localparam logic [NIB_W-1:0] FN_MAX_OP   = 4'h3;
  localparam logic [NIB_W-1:0] FN_NONE     = 4'h0;

  // instruction lengths in bytes
  localparam logic [NIB_W-1:0] LEN_NONE  = 4'd0;
  localparam logic [NIB_W-1:0] LEN_SHORT = 4'd1;
  localparam logic [NIB_W-1:0] LEN_REG   = 4'd2;
  localparam logic [NIB_W-1:0] LEN_DEST  = 4'd9;
  localparam logic [NIB_W-1:0] LEN_LONG  = 4'd10;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HALT    = 2'd1,
    ST_ADDR    = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  // where the constant comes from
  typedef enum logic [1:0] {
    KSEL_NONE  = 2'd0,
    KSEL_BYTE1 = 2'd1,
    KSEL_BYTE2 = 2'd2
  } ksel_e;

  // result of field decode
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [NIB_W-1:0]  kind;
    logic [NIB_W-1:0]  fn;
    logic [NIB_W-1:0]  reg_a;
    logic [NIB_W-1:0]  reg_b;
    logic [NIB_W-1:0]  len;
    logic              ok;
    ksel_e             ksel;
    logic [RAW_W-1:0]  raw;
  } dec_t;

  // result of constant select and end address sum
  typedef struct packed {
    logic [END_W-1:0]   end_addr;
    logic [NIB_W-1:0]   kind;
    logic [NIB_W-1:0]   fn;
    logic [NIB_W-1:0]   reg_a;
    logic [NIB_W-1:0]   reg_b;
    logic [NIB_W-1:0]   len;
    logic               ok;
    logic [CONST_W-1:0] konst;
  } sum_t;

  // finished result, in tdata order from the highest bit down
  typedef struct packed {
    logic [NIB_W-1:0]   len;
    logic [CONST_W-1:0] konst;
    logic [NIB_W-1:0]   reg_b;
    logic [NIB_W-1:0]   reg_a;
    logic [NIB_W-1:0]   fn;
    logic [NIB_W-1:0]   kind;
    status_e            status;
  } res_t;

endpackage

/* rtl/y86_instruction_decoder.sv */
// y86_instruction_decoder: Y86-64 instruction decoder, top level
// instantiates y86id_split, y86id_sum and y86id_status; depends on y86id_pkg
//
// usage
// - slave stream takes one fetch transaction: the fetch address and the ten
//   instruction bytes that start there
// - master stream gives one decoded transaction for each: status, class,
//   function code, register nibbles, 64-bit constant and length
// - three register stages: field decode, constant select with end address
//   sum, memory bound check with final status
// - an accepted input passes the field decode, constant select and status registers before it is valid
// - throughput is one transaction per cycle unless the receiver stalls; each stage holds one
//   transaction and takes a new one whenever it is empty or its content moves
// - when the receiver stalls, the output holds its transaction and the stages
//   behind it keep filling; s_axis_tready falls only once all three are full
// - reset clears the valid bits of all stages; no other state is kept
// - an address error is flagged when fetch address plus length exceeds
//   MEMORY_BYTES and overrides every other status

`timescale 1ns / 1ps

module y86_instruction_decoder #(
  parameter int unsigned MEMORY_BYTES = y86id_pkg::MEM_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // fetch_address [12:0], bytes_low [76:13], bytes_high [92:77], zero [95:93]
  input  logic [y86id_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status [1:0], kind [5:2], function_code [9:6], reg_a [13:10],
  // reg_b [17:14], constant [81:18], length [85:82], zero [87:86]
  output logic [y86id_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

  logic            dec_valid, dec_ready;
  y86id_pkg::dec_t dec_data;
  logic            sum_valid, sum_ready;
  y86id_pkg::sum_t sum_data;
  y86id_pkg::res_t res_data;

  // field decode
  y86id_split u_split (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .addr_i       (s_axis_tdata[12:0]),
    .bytes_low_i  (s_axis_tdata[76:13]),
    .bytes_high_i (s_axis_tdata[92:77]),
    .out_valid_o  (dec_valid),
    .out_ready_i  (dec_ready),
    .out_data_o   (dec_data)
  );

  // constant select and end address
  y86id_sum u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_ready_o  (dec_ready),
    .in_data_i   (dec_data),
    .out_valid_o (sum_valid),
    .out_ready_i (sum_ready),
    .out_data_o  (sum_data)
  );

  // bound check and status
  y86id_status #(
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_status (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sum_valid),
    .in_ready_o  (sum_ready),
    .in_data_i   (sum_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res_data)
  );

  assign m_axis_tdata = {2'b00, res_data};

endmodule

/* rtl/y86id_split.sv */
// y86id_split: first pipeline stage, splits byte 0 and 1 and runs the field checks
// depends on y86id_pkg

`timescale 1ns / 1ps

module y86id_split (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [y86id_pkg::ADDR_W-1:0]      addr_i,
  input  logic [63:0]                       bytes_low_i,
  input  logic [15:0]                       bytes_high_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output y86id_pkg::dec_t                   out_data_o
);

  logic            valid_q, valid_d;
  y86id_pkg::dec_t data_q, data_d;
  logic [3:0]      hi_nib, lo_nib;
  logic            ra_ok, rb_ok;

  assign hi_nib = bytes_low_i[15:12];
  assign lo_nib = bytes_low_i[11:8];
  assign ra_ok  = hi_nib != y86id_pkg::NO_REG;
  assign rb_ok  = lo_nib != y86id_pkg::NO_REG;

  // class decode and field checks
  always_comb begin
    data_d       = '0;
    data_d.addr  = addr_i;
    data_d.kind  = bytes_low_i[7:4];
    data_d.fn    = bytes_low_i[3:0];
    data_d.reg_a = y86id_pkg::NO_REG;
    data_d.reg_b = y86id_pkg::NO_REG;
    data_d.len   = y86id_pkg::LEN_NONE;
    data_d.ok    = 1'b0;
    data_d.ksel  = y86id_pkg::KSEL_NONE;
    data_d.raw   = {bytes_high_i, bytes_low_i[63:8]};
    unique case (data_d.kind) inside
      y86id_pkg::CLS_HALT, y86id_pkg::CLS_NOP, y86id_pkg::CLS_RET: begin
        data_d.len = y86id_pkg::LEN_SHORT;
        data_d.ok  = data_d.fn == y86id_pkg::FN_NONE;
      end
      y86id_pkg::CLS_CMOV: begin
        data_d.len   = y86id_pkg::LEN_REG;
        data_d.reg_a = hi_nib;
        data_d.reg_b = lo_nib;
        data_d.ok    = ra_ok && rb_ok && (data_d.fn <= y86id_pkg::FN_MAX_COND);
      end
      y86id_pkg::CLS_OPQ: begin
        data_d.len   = y86id_pkg::LEN_REG;
        data_d.reg_a = hi_nib;
        data_d.reg_b = lo_nib;
        data_d.ok    = ra_ok && rb_ok && (data_d.fn <= y86id_pkg::FN_MAX_OP);
      end
      y86id_pkg::CLS_IRMOVQ, y86id_pkg::CLS_RMMOVQ, y86id_pkg::CLS_MRMOVQ: begin
        data_d.len   = y86id_pkg::LEN_LONG;
        data_d.reg_a = hi_nib;
        data_d.reg_b = lo_nib;
        data_d.ksel  = y86id_pkg::KSEL_BYTE2;
        data_d.ok    = data_d.fn == y86id_pkg::FN_NONE;
        // irmovq wants no source register, mrmovq wants a destination
        if (data_d.kind == y86id_pkg::CLS_IRMOVQ) begin
          data_d.ok = data_d.ok && !ra_ok;
        end else if (data_d.kind == y86id_pkg::CLS_MRMOVQ) begin
          data_d.ok = data_d.ok && ra_ok;
        end
      end
      y86id_pkg::CLS_JXX: begin
        data_d.len  = y86id_pkg::LEN_DEST;
        data_d.ksel = y86id_pkg::KSEL_BYTE1;
        data_d.ok   = data_d.fn <= y86id_pkg::FN_MAX_COND;
      end
      y86id_pkg::CLS_CALL: begin
        data_d.len  = y86id_pkg::LEN_DEST;
        data_d.ksel = y86id_pkg::KSEL_BYTE1;
        data_d.ok   = data_d.fn == y86id_pkg::FN_NONE;
      end
      y86id_pkg::CLS_PUSHQ, y86id_pkg::CLS_POPQ: begin
        data_d.len   = y86id_pkg::LEN_REG;
        data_d.reg_a = hi_nib;
        data_d.reg_b = lo_nib;
        data_d.ok    = ra_ok && !rb_ok && (data_d.fn == y86id_pkg::FN_NONE);
      end
      default: begin
        // unknown class keeps the defaults and fails
        data_d.ok = 1'b0;
      end
    endcase
  end

  // stage handshake
  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* rtl/y86id_sum.sv */
// y86id_sum: second pipeline stage, picks the constant and adds length to the address
// depends on y86id_pkg

`timescale 1ns / 1ps

module y86id_sum (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  y86id_pkg::dec_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output y86id_pkg::sum_t out_data_o
);

  logic            valid_q, valid_d;
  y86id_pkg::sum_t data_q, data_d;

  // constant select and end address
  always_comb begin
    data_d          = '0;
    data_d.end_addr = {1'b0, in_data_i.addr}
                    + {{(y86id_pkg::END_W - y86id_pkg::NIB_W){1'b0}}, in_data_i.len};
    data_d.kind     = in_data_i.kind;
    data_d.fn       = in_data_i.fn;
    data_d.reg_a    = in_data_i.reg_a;
    data_d.reg_b    = in_data_i.reg_b;
    data_d.len      = in_data_i.len;
    data_d.ok       = in_data_i.ok;
    case (in_data_i.ksel)
      y86id_pkg::KSEL_BYTE1: data_d.konst = in_data_i.raw[63:0];
      y86id_pkg::KSEL_BYTE2: data_d.konst = in_data_i.raw[71:8];
      default:               data_d.konst = '0;
    endcase
  end

  // stage handshake
  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* rtl/y86id_status.sv */
// y86id_status: last pipeline stage, memory bound check, final status, output register
// depends on y86id_pkg

`timescale 1ns / 1ps

module y86id_status #(
  parameter int unsigned MEMORY_BYTES = y86id_pkg::MEM_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  y86id_pkg::sum_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output y86id_pkg::res_t out_data_o
);

  localparam int unsigned LimW = $clog2(MEMORY_BYTES + 1);
  localparam int unsigned CmpW = (LimW > y86id_pkg::END_W) ? LimW : y86id_pkg::END_W;
  localparam logic [CmpW-1:0] Limit = CmpW'(MEMORY_BYTES);

  logic            valid_q, valid_d;
  y86id_pkg::res_t data_q, data_d;
  logic [CmpW-1:0] end_ext;
  logic            out_of_range;

  assign end_ext      = CmpW'(in_data_i.end_addr);
  assign out_of_range = end_ext > Limit;

  // status priority: address error, then invalid, then halt
  always_comb begin
    data_d.len   = in_data_i.len;
    data_d.konst = in_data_i.konst;
    data_d.reg_b = in_data_i.reg_b;
    data_d.reg_a = in_data_i.reg_a;
    data_d.fn    = in_data_i.fn;
    data_d.kind  = in_data_i.kind;
    if (out_of_range) begin
      data_d.status = y86id_pkg::ST_ADDR;
    end else if (!in_data_i.ok) begin
      data_d.status = y86id_pkg::ST_INVALID;
    end else if (in_data_i.kind == y86id_pkg::CLS_HALT) begin
      data_d.status = y86id_pkg::ST_HALT;
    end else begin
      data_d.status = y86id_pkg::ST_OK;
    end
  end

  // stage handshake
  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* rtl/y86id_checker.sv */
// y86id_checker: port-level assertions for the decoder and the bind that attaches them
// depends on y86id_pkg and y86_instruction_decoder

`timescale 1ns / 1ps

module y86id_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [y86id_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic [1:0] st;
  logic [3:0] kind;
  logic [3:0] len;

  assign st   = m_axis_tdata[1:0];
  assign kind = m_axis_tdata[5:2];
  assign len  = m_axis_tdata[85:82];

  // a stalled output transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  // nothing leaves while reset is held
  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  // halt status only for a one-byte halt
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == y86id_pkg::ST_HALT |->
      kind == y86id_pkg::CLS_HALT && len == y86id_pkg::LEN_SHORT)
    else $error("halt status on a non-halt instruction");

  // an unknown class never passes
  a_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && len == y86id_pkg::LEN_NONE |->
      st == y86id_pkg::ST_INVALID || st == y86id_pkg::ST_ADDR)
    else $error("unknown class reported as valid");

  // length follows the class for jump and call
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind == y86id_pkg::CLS_JXX || kind == y86id_pkg::CLS_CALL) |->
      len == y86id_pkg::LEN_DEST)
    else $error("wrong length for jump or call");

endmodule

bind y86_instruction_decoder y86id_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
